// File: hw/rtl/png1_pkg.sv
package png1_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [6:0] t_pos;

    // effective (already clamped) image geometry
    typedef struct packed {
        logic [6:0] row_bytes;
        logic [9:0] image_rows;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_HEAD,
        ST_FILT,
        ST_PIX,
        ST_TRL
    } t_start;

    // one classified item for the back end
    typedef struct packed {
        t_start start;
        logic   to_trl;
        t_byte  px;
    } t_cmd;

    localparam int Q_DEPTH = 4;

    localparam logic [0:0] REG_ROW_BYTES  = 1'b0;
    localparam logic [0:0] REG_IMAGE_ROWS = 1'b1;

    localparam logic [6:0] ROW_BYTES_RST  = 7'd16;
    localparam logic [9:0] IMAGE_ROWS_RST = 10'd128;
    localparam logic [6:0] ROW_BYTES_MAX  = 7'd64;
    localparam logic [9:0] IMAGE_ROWS_MAX = 10'd1008;

    localparam logic [31:0] CRC_POLY  = 32'hedb88320;
    localparam logic [31:0] ALL_ONES  = 32'hffffffff;
    localparam logic [16:0] ADLER_MOD = 17'd65521;

    localparam logic [63:0] PNG_SIG  = 64'h89504e470d0a1a0a;
    localparam logic [31:0] TAG_IHDR = 32'h49484452;
    localparam logic [31:0] TAG_IDAT = 32'h49444154;
    localparam logic [31:0] TAG_IEND = 32'h49454e44;
    localparam logic [31:0] CRC_IEND = 32'hae426082;
    localparam t_byte ZLIB_CMF  = 8'h78;
    localparam t_byte ZLIB_FLG  = 8'h01;
    localparam t_byte BLK_FINAL = 8'h01;
    localparam t_byte IHDR_DEPTH = 8'h01;

    // byte positions within the file stream
    localparam t_pos P_SIG      = 7'd0;
    localparam t_pos P_IHDR_LEN = 7'd8;
    localparam t_pos P_IHDR_TAG = 7'd12;
    localparam t_pos P_IHDR_DAT = 7'd16;
    localparam t_pos P_IHDR_CRC = 7'd29;
    localparam t_pos P_IDAT_LEN = 7'd33;
    localparam t_pos P_IDAT_TAG = 7'd37;
    localparam t_pos P_ZLIB_CMF = 7'd41;
    localparam t_pos P_ZLIB_FLG = 7'd42;
    localparam t_pos P_BLK_HDR  = 7'd43;
    localparam t_pos P_LEN_LO   = 7'd44;
    localparam t_pos P_LEN_HI   = 7'd45;
    localparam t_pos P_NLEN_LO  = 7'd46;
    localparam t_pos P_NLEN_HI  = 7'd47;
    localparam t_pos P_FILT     = 7'd48;
    localparam t_pos P_PIX      = 7'd49;
    localparam t_pos P_ADLER    = 7'd50;
    localparam t_pos P_IDAT_CRC = 7'd54;
    localparam t_pos P_IEND_LEN = 7'd58;
    localparam t_pos P_IEND_TAG = 7'd62;
    localparam t_pos P_IEND_CRC = 7'd66;
    localparam t_pos P_END      = 7'd69;

    // IHDR data offsets
    localparam logic [3:0] IH_W_HI    = 4'd2;
    localparam logic [3:0] IH_W_LO    = 4'd3;
    localparam logic [3:0] IH_H_HI    = 4'd6;
    localparam logic [3:0] IH_H_LO    = 4'd7;
    localparam logic [3:0] IH_DEPTH   = 4'd8;

    function automatic logic [6:0] clamp_row_bytes(input logic [6:0] v);
        if (v == 7'd0) begin
            return 7'd1;
        end
        return (v > ROW_BYTES_MAX) ? ROW_BYTES_MAX : v;
    endfunction

    function automatic logic [9:0] clamp_image_rows(input logic [9:0] v);
        if (v == 10'd0) begin
            return 10'd1;
        end
        return (v > IMAGE_ROWS_MAX) ? IMAGE_ROWS_MAX : v;
    endfunction

endpackage

// File: hw/rtl/png1_in_if.sv
interface png1_in_if;
    logic             valid;
    logic             ready;
    png1_pkg::t_byte  pixel_byte;

    modport source(output valid, output pixel_byte, input ready);
    modport sink(input valid, input pixel_byte, output ready);
endinterface

// File: hw/rtl/png1_out_if.sv
interface png1_out_if;
    logic             valid;
    logic             ready;
    png1_pkg::t_byte  out_byte;
    logic             run_last;
    logic             file_end;

    modport source(output valid, output out_byte, output run_last, output file_end,
                   input ready);
    modport sink(input valid, input out_byte, input run_last, input file_end,
                 output ready);
endinterface

// File: hw/rtl/png1_front.sv
module png1_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  png1_pkg::t_cfg   i_cfg,
    png1_in_if.sink          i_in,
    input  logic             i_q_ready,
    output logic             o_push,
    output png1_pkg::t_cmd   o_cmd
);

    logic [5:0] r_bir, n_bir;
    logic [9:0] r_row, n_row;
    logic       r_hdr, n_hdr;
    logic       r_pend, n_pend;

    logic [6:0]  bir_inc;
    logic [10:0] row_inc;

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;
    assign bir_inc    = {1'b0, r_bir} + 7'd1;
    assign row_inc    = {1'b0, r_row} + 11'd1;

    always_comb begin
        n_bir  = r_bir;
        n_row  = r_row;
        n_hdr  = r_hdr;
        n_pend = r_pend;
        o_cmd.px     = ~i_in.pixel_byte;
        o_cmd.to_trl = 1'b0;
        o_cmd.start  = png1_pkg::ST_PIX;
        if (r_pend) begin
            // trailer owed from a one-byte image; this item's pixels are dropped
            o_cmd.start  = png1_pkg::ST_TRL;
            o_cmd.to_trl = 1'b1;
            n_bir  = '0;
            n_row  = '0;
            n_hdr  = 1'b0;
            n_pend = 1'b0;
        end else begin
            if (!r_hdr) begin
                o_cmd.start = png1_pkg::ST_HEAD;
            end else if (r_bir == 6'd0) begin
                o_cmd.start = png1_pkg::ST_FILT;
            end
            n_hdr = 1'b1;
            n_bir = bir_inc[5:0];
            if (bir_inc >= i_cfg.row_bytes) begin
                n_bir = '0;
                n_row = row_inc[9:0];
                if (row_inc >= {1'b0, i_cfg.image_rows}) begin
                    if (!r_hdr) begin
                        // header plus pixel already fill the run
                        n_pend = 1'b1;
                    end else begin
                        o_cmd.to_trl = 1'b1;
                        n_bir = '0;
                        n_row = '0;
                        n_hdr = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bir  <= '0;
            r_row  <= '0;
            r_hdr  <= 1'b0;
            r_pend <= 1'b0;
        end else if (o_push) begin
            r_bir  <= n_bir;
            r_row  <= n_row;
            r_hdr  <= n_hdr;
            r_pend <= n_pend;
        end
    end

endmodule

// File: hw/rtl/png1_queue.sv
module png1_queue #(
    parameter int DEPTH = png1_pkg::Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  png1_pkg::t_cmd   i_cmd,
    output logic             o_ready,
    output logic             o_valid,
    output png1_pkg::t_cmd   o_cmd,
    input  logic             i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    png1_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;
    logic           do_push, do_pop;

    assign o_ready = (r_cnt != FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// File: hw/rtl/png1_back.sv
module png1_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  png1_pkg::t_cfg   i_cfg,
    input  logic             i_q_valid,
    input  png1_pkg::t_cmd   i_cmd,
    output logic             o_pop,
    png1_out_if.source       o_out
);

    png1_pkg::t_pos  r_pos;
    logic            r_act;
    logic            r_ov;
    png1_pkg::t_byte r_ob;
    logic            r_rl, r_fe;
    logic [31:0]     r_crc;
    logic [15:0]     r_alo, r_ahi;
    logic [15:0]     r_raw_len, r_idat_len;

    png1_pkg::t_pos  start_pos, end_pos, cur, off;
    png1_pkg::t_byte cur_byte;
    logic            take, emit, is_last;
    logic [16:0]     sum_lo, sum_hi;
    logic [15:0]     n_alo, n_ahi;
    logic [16:0]     prod;

    function automatic png1_pkg::t_byte be_byte(input logic [31:0] v, input logic [1:0] idx);
        case (idx)
            2'd0:    return v[31:24];
            2'd1:    return v[23:16];
            2'd2:    return v[15:8];
            default: return v[7:0];
        endcase
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input png1_pkg::t_byte b);
        logic [31:0] v;
        v = c ^ {24'b0, b};
        for (int k = 0; k < 8; k++) begin
            v = (v >> 1) ^ (v[0] ? png1_pkg::CRC_POLY : 32'b0);
        end
        return v;
    endfunction

    assign prod = i_cfg.image_rows * ({1'b0, i_cfg.row_bytes} + 8'd1);

    always_comb begin
        unique case (i_cmd.start)
            png1_pkg::ST_HEAD: start_pos = png1_pkg::P_SIG;
            png1_pkg::ST_FILT: start_pos = png1_pkg::P_FILT;
            png1_pkg::ST_PIX:  start_pos = png1_pkg::P_PIX;
            png1_pkg::ST_TRL:  start_pos = png1_pkg::P_ADLER;
        endcase
    end

    assign end_pos = i_cmd.to_trl ? png1_pkg::P_END : png1_pkg::P_PIX;
    assign cur     = r_act ? r_pos : start_pos;
    assign take    = !r_ov || o_out.ready;
    assign emit    = i_q_valid && take;
    assign is_last = (cur == end_pos);
    assign o_pop   = emit && is_last;

    always_comb begin
        off      = '0;
        cur_byte = '0;
        case (cur) inside
            [png1_pkg::P_SIG : png1_pkg::P_IHDR_LEN - 7'd1]:
                cur_byte = png1_pkg::PNG_SIG[8 * (7 - int'(cur[2:0])) +: 8];
            [png1_pkg::P_IHDR_LEN : png1_pkg::P_IHDR_TAG - 7'd1]: begin
                off      = cur - png1_pkg::P_IHDR_LEN;
                cur_byte = be_byte(32'd13, off[1:0]);
            end
            [png1_pkg::P_IHDR_TAG : png1_pkg::P_IHDR_DAT - 7'd1]: begin
                off      = cur - png1_pkg::P_IHDR_TAG;
                cur_byte = be_byte(png1_pkg::TAG_IHDR, off[1:0]);
            end
            [png1_pkg::P_IHDR_DAT : png1_pkg::P_IHDR_CRC - 7'd1]: begin
                off = cur - png1_pkg::P_IHDR_DAT;
                case (off[3:0])
                    png1_pkg::IH_W_HI:  cur_byte = {6'b0, i_cfg.row_bytes[6:5]};
                    png1_pkg::IH_W_LO:  cur_byte = {i_cfg.row_bytes[4:0], 3'b0};
                    png1_pkg::IH_H_HI:  cur_byte = {6'b0, i_cfg.image_rows[9:8]};
                    png1_pkg::IH_H_LO:  cur_byte = i_cfg.image_rows[7:0];
                    png1_pkg::IH_DEPTH: cur_byte = png1_pkg::IHDR_DEPTH;
                    default:            cur_byte = '0;
                endcase
            end
            [png1_pkg::P_IHDR_CRC : png1_pkg::P_IDAT_LEN - 7'd1]: begin
                off      = cur - png1_pkg::P_IHDR_CRC;
                cur_byte = be_byte(~r_crc, off[1:0]);
            end
            [png1_pkg::P_IDAT_LEN : png1_pkg::P_IDAT_TAG - 7'd1]: begin
                off      = cur - png1_pkg::P_IDAT_LEN;
                cur_byte = be_byte({16'b0, r_idat_len}, off[1:0]);
            end
            [png1_pkg::P_IDAT_TAG : png1_pkg::P_ZLIB_CMF - 7'd1]: begin
                off      = cur - png1_pkg::P_IDAT_TAG;
                cur_byte = be_byte(png1_pkg::TAG_IDAT, off[1:0]);
            end
            png1_pkg::P_ZLIB_CMF: cur_byte = png1_pkg::ZLIB_CMF;
            png1_pkg::P_ZLIB_FLG: cur_byte = png1_pkg::ZLIB_FLG;
            png1_pkg::P_BLK_HDR:  cur_byte = png1_pkg::BLK_FINAL;
            png1_pkg::P_LEN_LO:   cur_byte = r_raw_len[7:0];
            png1_pkg::P_LEN_HI:   cur_byte = r_raw_len[15:8];
            png1_pkg::P_NLEN_LO:  cur_byte = ~r_raw_len[7:0];
            png1_pkg::P_NLEN_HI:  cur_byte = ~r_raw_len[15:8];
            png1_pkg::P_FILT:     cur_byte = '0;
            png1_pkg::P_PIX:      cur_byte = i_cmd.px;
            [png1_pkg::P_ADLER : png1_pkg::P_IDAT_CRC - 7'd1]: begin
                off      = cur - png1_pkg::P_ADLER;
                cur_byte = be_byte({r_ahi, r_alo}, off[1:0]);
            end
            [png1_pkg::P_IDAT_CRC : png1_pkg::P_IEND_LEN - 7'd1]: begin
                off      = cur - png1_pkg::P_IDAT_CRC;
                cur_byte = be_byte(~r_crc, off[1:0]);
            end
            [png1_pkg::P_IEND_TAG : png1_pkg::P_IEND_CRC - 7'd1]: begin
                off      = cur - png1_pkg::P_IEND_TAG;
                cur_byte = be_byte(png1_pkg::TAG_IEND, off[1:0]);
            end
            [png1_pkg::P_IEND_CRC : png1_pkg::P_END]: begin
                off      = cur - png1_pkg::P_IEND_CRC;
                cur_byte = be_byte(png1_pkg::CRC_IEND, off[1:0]);
            end
            default: cur_byte = '0;
        endcase
    end

    // Adler-32 over the raw scanline bytes, both halves reduced by one subtract
    always_comb begin
        sum_lo = {1'b0, r_alo} + {9'b0, cur_byte};
        n_alo  = (sum_lo >= png1_pkg::ADLER_MOD) ? 16'(sum_lo - png1_pkg::ADLER_MOD)
                                                 : sum_lo[15:0];
        sum_hi = {1'b0, r_ahi} + {1'b0, n_alo};
        n_ahi  = (sum_hi >= png1_pkg::ADLER_MOD) ? 16'(sum_hi - png1_pkg::ADLER_MOD)
                                                 : sum_hi[15:0];
    end

    always_ff @(posedge i_clk) begin
        r_raw_len  <= prod[15:0];
        r_idat_len <= r_raw_len + 16'd11;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_pos <= '0;
            r_ov  <= 1'b0;
            r_crc <= png1_pkg::ALL_ONES;
            r_alo <= 16'd1;
            r_ahi <= 16'd0;
        end else begin
            if (take) begin
                r_ov <= emit;
            end
            if (emit) begin
                r_act <= !is_last;
                r_pos <= cur + 7'd1;
                // CRC restarts ahead of the IHDR and IDAT chunk type fields
                if (cur == png1_pkg::P_IHDR_TAG - 7'd1 ||
                    cur == png1_pkg::P_IDAT_TAG - 7'd1) begin
                    r_crc <= png1_pkg::ALL_ONES;
                end else if ((cur >= png1_pkg::P_IHDR_TAG && cur < png1_pkg::P_IHDR_CRC) ||
                             (cur >= png1_pkg::P_IDAT_TAG && cur < png1_pkg::P_IDAT_CRC)) begin
                    r_crc <= crc_byte(r_crc, cur_byte);
                end
                if (cur == png1_pkg::P_FILT || cur == png1_pkg::P_PIX) begin
                    r_alo <= n_alo;
                    r_ahi <= n_ahi;
                end else if (cur == png1_pkg::P_END) begin
                    r_alo <= 16'd1;
                    r_ahi <= 16'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ob <= cur_byte;
            r_rl <= is_last;
            r_fe <= (cur == png1_pkg::P_END);
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_ob;
    assign o_out.run_last = r_rl;
    assign o_out.file_end = r_fe;

endmodule

// File: hw/rtl/png_1bpp_stored_encoder.sv
// channel   dir  payload                          handshake
// i_in      in   pixel_byte[7:0]                  valid/ready
// o_out     out  out_byte[7:0] run_last file_end  valid/ready
// i_cfg_*   in   idx[0] data[9:0]                 write enable, no back-pressure
//
// The back end emits one output byte per cycle while the queue holds an item and
// the output is not stalled; an item causes 1 byte for a plain pixel, 2 at a row
// start, 50 for the first item of a file, 20 more for the trailer. The front end
// takes one item per cycle while the command queue has room, so the byte rate of
// the back end sets the sustained figure. Reset is synchronous and clears counters
// and the queue; either side may stall without loss.
module png_1bpp_stored_encoder #(
    parameter int QDEPTH = png1_pkg::Q_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    png1_in_if.sink     i_in,
    png1_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [9:0]  i_cfg_data
);

    png1_pkg::t_cfg r_cfg;
    png1_pkg::t_cmd push_cmd, head_cmd;
    logic           push, q_ready, q_valid, pop;

    // registers hold the clamped values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_bytes  <= png1_pkg::ROW_BYTES_RST;
            r_cfg.image_rows <= png1_pkg::IMAGE_ROWS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                png1_pkg::REG_ROW_BYTES:
                    r_cfg.row_bytes <= png1_pkg::clamp_row_bytes(i_cfg_data[6:0]);
                png1_pkg::REG_IMAGE_ROWS:
                    r_cfg.image_rows <= png1_pkg::clamp_image_rows(i_cfg_data);
            endcase
        end
    end

    png1_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    png1_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    png1_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .o_out     (o_out)
    );

    a_end_is_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.file_end) |-> o_out.run_last)
        else $error("file end without run end");

    a_cfg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cfg.row_bytes != 7'd0 && r_cfg.row_bytes <= png1_pkg::ROW_BYTES_MAX &&
        r_cfg.image_rows != 10'd0 && r_cfg.image_rows <= png1_pkg::IMAGE_ROWS_MAX)
        else $error("geometry out of range");

    a_no_byte_from_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_valid |=> !$rose(o_out.valid))
        else $error("output byte with empty queue");

    a_pop_on_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (o_out.ready || !o_out.valid)) |=> (o_out.valid && o_out.run_last))
        else $error("queue popped without run end");

endmodule

// File: bench/png_1bpp_stored_encoder_tb.sv
`timescale 1ns / 1ps

module png_1bpp_stored_encoder_tb;

    localparam int unsigned MAX_BYTES_PER_ITEM = 50;
    localparam int unsigned TRAILER_LEN        = 20;
    localparam logic [31:0] ADLER_BASE         = 32'd65521;
    localparam logic [31:0] CRC32_POLY         = 32'hedb88320;
    localparam logic [31:0] CRC32_INIT         = 32'hffffffff;
    localparam logic [63:0] FILE_MAGIC         = 64'h89504e470d0a1a0a;
    localparam logic [31:0] CHUNK_IHDR         = 32'h49484452;
    localparam logic [31:0] CHUNK_IDAT         = 32'h49444154;
    localparam logic [31:0] CHUNK_IEND         = 32'h49454e44;
    localparam logic [7:0]  ZLIB_CMF_BYTE      = 8'h78;
    localparam logic [7:0]  ZLIB_FLG_BYTE      = 8'h01;
    localparam logic [7:0]  STORED_FINAL_BYTE  = 8'h01;
    localparam logic [7:0]  IHDR_BIT_DEPTH     = 8'h01;
    localparam logic [7:0]  FILTER_NONE        = 8'h00;
    localparam int unsigned STALL_LIMIT        = 2000;
    localparam int unsigned RANDOM_ITEMS       = 100;
    localparam int unsigned MAX_PRINTED        = 100;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       file_end;
    } t_file_byte;

    class png_stream_sb;
        logic [6:0]  row_bytes_reg;
        logic [9:0]  rows_reg;
        logic [31:0] idat_crc;
        logic [31:0] adler_lo;
        logic [31:0] adler_hi;
        int unsigned col;
        int unsigned row;
        bit          header_done;
        bit          trailer_owed;
        t_file_byte  call_bytes[$];
        t_file_byte  file_bytes_due[$];
        int unsigned mismatches;
        int unsigned bytes_checked;
        int unsigned files_seen;

        function new();
            row_bytes_reg = 7'd16;
            rows_reg      = 10'd128;
            mismatches    = 0;
            bytes_checked = 0;
            files_seen    = 0;
            clear_file();
        endfunction

        function void clear_file();
            idat_crc     = CRC32_INIT;
            adler_lo     = 32'd1;
            adler_hi     = 32'd0;
            col          = 0;
            row          = 0;
            header_done  = 0;
            trailer_owed = 0;
        endfunction

        function void set_reg(logic [0:0] idx, logic [9:0] data);
            if (idx == png1_pkg::REG_ROW_BYTES) begin
                row_bytes_reg = data[6:0];
            end else begin
                rows_reg = data;
            end
        endfunction

        function int unsigned eff_row_bytes();
            if (row_bytes_reg == 7'd0) begin
                return 1;
            end
            return (row_bytes_reg > 7'd64) ? 64 : row_bytes_reg;
        endfunction

        function int unsigned eff_rows();
            if (rows_reg == 10'd0) begin
                return 1;
            end
            return (rows_reg > 10'd1008) ? 1008 : rows_reg;
        endfunction

        function logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
            logic [31:0] r;
            r = c ^ {24'd0, b};
            for (int k = 0; k < 8; k++) begin
                r = r[0] ? ((r >> 1) ^ CRC32_POLY) : (r >> 1);
            end
            return r;
        endfunction

        // bytes past the per-item ceiling are dropped
        function void put(logic [7:0] b);
            t_file_byte fb;
            if (call_bytes.size() < MAX_BYTES_PER_ITEM) begin
                fb.data     = b;
                fb.run_last = 1'b0;
                fb.file_end = 1'b0;
                call_bytes.push_back(fb);
            end
        endfunction

        function void put_crc(logic [7:0] b);
            idat_crc = crc32_step(idat_crc, b);
            put(b);
        endfunction

        // scanline byte: feeds Adler-32 and the IDAT CRC
        function void put_scan(logic [7:0] b);
            adler_lo = adler_lo + {24'd0, b};
            if (adler_lo >= ADLER_BASE) begin
                adler_lo = adler_lo - ADLER_BASE;
            end
            adler_hi = adler_hi + adler_lo;
            if (adler_hi >= ADLER_BASE) begin
                adler_hi = adler_hi - ADLER_BASE;
            end
            put_crc(b);
        endfunction

        function void put_word(logic [31:0] v, bit with_crc);
            for (int s = 3; s >= 0; s--) begin
                if (with_crc) begin
                    put_crc(v[8*s +: 8]);
                end else begin
                    put(v[8*s +: 8]);
                end
            end
        endfunction

        function void send_header();
            logic [7:0]  ihdr [13];
            logic [15:0] width;
            logic [15:0] rows16;
            logic [31:0] raw_len;
            logic [31:0] nlen;
            logic [31:0] c;
            width   = 16'(eff_row_bytes() * 8);
            rows16  = 16'(eff_rows());
            raw_len = eff_rows() * (eff_row_bytes() + 1);
            nlen    = ~raw_len;
            ihdr = '{8'h00, 8'h00, width[15:8], width[7:0], 8'h00, 8'h00,
                     rows16[15:8], rows16[7:0], IHDR_BIT_DEPTH, 8'h00, 8'h00, 8'h00, 8'h00};

            put_word(FILE_MAGIC[63:32], 0);
            put_word(FILE_MAGIC[31:0], 0);
            put_word(32'd13, 0);
            c = CRC32_INIT;
            for (int i = 3; i >= 0; i--) begin
                c = crc32_step(c, CHUNK_IHDR[8*i +: 8]);
                put(CHUNK_IHDR[8*i +: 8]);
            end
            for (int i = 0; i < 13; i++) begin
                c = crc32_step(c, ihdr[i]);
                put(ihdr[i]);
            end
            put_word(c ^ CRC32_INIT, 0);

            // IDAT: zlib header, then one final stored block holding every scanline
            put_word(raw_len + 32'd11, 0);
            idat_crc = CRC32_INIT;
            put_word(CHUNK_IDAT, 1);
            put_crc(ZLIB_CMF_BYTE);
            put_crc(ZLIB_FLG_BYTE);
            put_crc(STORED_FINAL_BYTE);
            put_crc(raw_len[7:0]);
            put_crc(raw_len[15:8]);
            put_crc(nlen[7:0]);
            put_crc(nlen[15:8]);
            header_done = 1;
        endfunction

        function void send_trailer();
            logic [31:0] c;
            t_file_byte  fb;
            put_word({adler_hi[15:0], adler_lo[15:0]}, 1);
            put_word(idat_crc ^ CRC32_INIT, 0);
            put_word(32'd0, 0);
            c = CRC32_INIT;
            for (int i = 3; i >= 0; i--) begin
                c = crc32_step(c, CHUNK_IEND[8*i +: 8]);
                put(CHUNK_IEND[8*i +: 8]);
            end
            put_word(c ^ CRC32_INIT, 0);
            if (call_bytes.size() > 0) begin
                fb = call_bytes.pop_back();
                fb.file_end = 1'b1;
                call_bytes.push_back(fb);
            end
            clear_file();
        endfunction

        function void encode_pixel(logic [7:0] px);
            bit         image_done;
            t_file_byte fb;
            call_bytes.delete();
            if (trailer_owed) begin
                // pixel ignored: this item only carries the owed trailer out
                send_trailer();
            end else begin
                image_done = 0;
                if (!header_done) begin
                    send_header();
                end
                if (col == 0) begin
                    put_scan(FILTER_NONE);
                end
                put_scan(~px);
                col++;
                if (col >= eff_row_bytes()) begin
                    col = 0;
                    row++;
                    if (row >= eff_rows()) begin
                        image_done = 1;
                    end
                end
                if (image_done) begin
                    if (call_bytes.size() + TRAILER_LEN > MAX_BYTES_PER_ITEM) begin
                        trailer_owed = 1;
                    end else begin
                        send_trailer();
                    end
                end
            end
            if (call_bytes.size() > 0) begin
                fb = call_bytes.pop_back();
                fb.run_last = 1'b1;
                call_bytes.push_back(fb);
            end
            foreach (call_bytes[i]) begin
                file_bytes_due.push_back(call_bytes[i]);
            end
        endfunction

        // items still needed to close the current file under the present geometry
        function int unsigned items_left();
            int unsigned c;
            int unsigned r;
            int unsigned n;
            if (trailer_owed) begin
                return 1;
            end
            c = col;
            r = row;
            n = 0;
            while (1) begin
                n++;
                c++;
                if (c >= eff_row_bytes()) begin
                    c = 0;
                    r++;
                    if (r >= eff_rows()) begin
                        break;
                    end
                end
            end
            if (!header_done && n == 1) begin
                n++;
            end
            return n;
        endfunction

        task report_mismatch(string msg);
            if (mismatches < MAX_PRINTED) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
            mismatches++;
        endtask

        task check_byte(logic [7:0] b, logic rl, logic fe);
            t_file_byte want;
            if (file_bytes_due.size() == 0) begin
                report_mismatch($sformatf("byte %02h arrived with nothing due", b));
            end else begin
                want = file_bytes_due.pop_front();
                if (b !== want.data) begin
                    report_mismatch($sformatf("byte %0d out_byte %02h, want %02h",
                                              bytes_checked, b, want.data));
                end
                if (rl !== want.run_last) begin
                    report_mismatch($sformatf("byte %0d run_last %b, want %b",
                                              bytes_checked, rl, want.run_last));
                end
                if (fe !== want.file_end) begin
                    report_mismatch($sformatf("byte %0d file_end %b, want %b",
                                              bytes_checked, fe, want.file_end));
                end
            end
            if (fe === 1'b1) begin
                files_seen++;
            end
            bytes_checked++;
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [0:0] cfg_idx;
    logic [9:0] cfg_data;

    png1_in_if  pix_if();
    png1_out_if file_if();

    png_stream_sb sb = new();

    int unsigned src_idle_pct = 11;
    int unsigned snk_idle_pct = 47;
    int unsigned items_sent   = 0;
    int unsigned random_items = 0;
    int unsigned reg_writes   = 0;
    bit          wide_row_done = 0;

    png_1bpp_stored_encoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (pix_if),
        .o_out      (file_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        file_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pix_if.valid && pix_if.ready) begin
                sb.encode_pixel(pix_if.pixel_byte);
            end
            if (file_if.valid && file_if.ready) begin
                sb.check_byte(file_if.out_byte, file_if.run_last, file_if.file_end);
            end
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((pix_if.valid && pix_if.ready) || (file_if.valid && file_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout: %0d cycles with no item moving, %0d bytes still due",
                 quiet, sb.file_bytes_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

    task send_item(logic [7:0] px);
        if (items_sent < 45) begin
            src_idle_pct = 11;
            snk_idle_pct = 47;
        end else if (items_sent < 90) begin
            src_idle_pct = 47;
            snk_idle_pct = 11;
        end else begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_if.valid      <= 1'b1;
        pix_if.pixel_byte <= px;
        do begin
            @(posedge i_clk);
        end while (!pix_if.ready);
        items_sent++;
    endtask

    task write_reg(logic [0:0] idx, logic [9:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        reg_writes++;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task set_geometry(logic [9:0] rb, logic [9:0] rows);
        write_reg(png1_pkg::REG_ROW_BYTES, rb);
        write_reg(png1_pkg::REG_IMAGE_ROWS, rows);
    endtask

    // drop valid and let every due byte drain before touching the registers
    task wait_idle();
        @(negedge i_clk);
        pix_if.valid <= 1'b0;
        while (sb.file_bytes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int unsigned pick;
        int unsigned n;
        logic [7:0]  px;
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = '0;
        cfg_data          = '0;
        pix_if.valid      = 1'b0;
        pix_if.pixel_byte = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry, left mid-image
        send_item(8'h00);
        send_item(8'hff);
        // geometry shrunk mid-image, zero rows read as one: this item ends the file
        wait_idle();
        set_geometry(10'd3, 10'd0);
        send_item(8'ha5);
        // single-byte image, zero row bytes read as one; trailer comes on the next item
        wait_idle();
        set_geometry(10'd0, 10'd1);
        send_item(8'h80);
        send_item(8'h01);
        // both registers above range, all data bits set
        wait_idle();
        set_geometry(10'h3ff, 10'h3ff);
        send_item(8'h7f);
        send_item(8'hfe);
        wait_idle();
        set_geometry(10'd2, 10'd1);
        send_item(8'h3c);
        // largest legal geometry in the header, then cut short
        wait_idle();
        set_geometry(10'd64, 10'd1008);
        send_item(8'h01);
        wait_idle();
        set_geometry(10'd1, 10'd1);
        send_item(8'h10);
        wait_idle();
        set_geometry(10'd2, 10'd2);
        send_item(8'h00);
        send_item(8'hff);
        send_item(8'h55);
        send_item(8'haa);

        // mostly whole files of random size and content, some cut-off files under noise
        while (random_items < RANDOM_ITEMS) begin
            wait_idle();
            pick = $urandom_range(19);
            if (pick == 0 && !wide_row_done) begin
                wide_row_done = 1;
                set_geometry(10'd64, 10'd1);
                n = sb.items_left();
            end else if (pick <= 2) begin
                set_geometry(10'd1, 10'd1);
                n = sb.items_left();
            end else if (pick <= 5) begin
                set_geometry(10'($urandom_range(1023)), 10'($urandom_range(1023)));
                n = $urandom_range(5, 1);
            end else begin
                set_geometry(10'($urandom_range(6, 1)), 10'($urandom_range(4, 1)));
                n = sb.items_left();
            end
            repeat (n) begin
                if ($urandom_range(7) == 0) begin
                    px = $urandom_range(1) ? 8'hff : 8'h00;
                end else begin
                    px = 8'($urandom_range(255));
                end
                send_item(px);
                random_items++;
            end
        end

        wait_idle();
        repeat (80) @(posedge i_clk);
        if (sb.file_bytes_due.size() != 0) begin
            sb.report_mismatch($sformatf("%0d bytes never arrived", sb.file_bytes_due.size()));
        end
        $display("covered %0d pixel items (%0d random) over %0d register writes",
                 items_sent, random_items, reg_writes);
        $display("checked %0d file bytes, %0d complete files, %0d mismatches",
                 sb.bytes_checked, sb.files_seen, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
